// ===== sv/periodic_timer_table_unit_defines.svh =====
// Assertion macros for the periodic timer table RTL.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef PERIODIC_TIMER_TABLE_UNIT_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define PTT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("ptt assertion failed");
// Check that a condition never holds outside reset.
`define PTT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("ptt forbidden condition");
`else
`define PTT_ASSERT(lbl, clk, rst_n, prop)
`define PTT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== sv/ptt_pkg.sv =====
// Package for the periodic timer table: sizes, payload structs, codes.
// Used by every module of the block; depends on nothing.
`default_nettype none
package ptt_pkg;
	localparam int SLOTS = 16;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int PADDR_W = 2;
	localparam logic [15:0] SKEW_THR_RESET = 16'd1000;

	localparam logic [1:0] OP_ADD      = 2'd0;
	localparam logic [1:0] OP_ADD_LATE = 2'd1;
	localparam logic [1:0] OP_REMOVE   = 2'd2;
	localparam logic [1:0] OP_PROCESS  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NO_TIMERS = 2'd3;

	localparam logic KIND_FIRED  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] now_ms;
		logic [15:0] owner_key;
		logic [23:0] interval_ms;
		logic        fire_once;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  slot;
		logic [15:0] fired_key;
		logic [1:0]  status;
		logic [31:0] delay_ms;
		logic        skew_corrected;
		logic        last;
	} result_t;

	typedef enum logic [3:0] {
		EM_NONE, EM_FIRE, EM_ADD, EM_FULL, EM_REM_OK, EM_NOT_FOUND,
		EM_NO_TIMERS, EM_OVERDUE, EM_DELAY, EM_SKEW
	} emit_t;

	typedef enum logic [3:0] {
		S_IDLE, S_ADD, S_REM, S_FIRE, S_DIV, S_REARM, S_MIN, S_DECIDE, S_SKEW
	} state_t;

	typedef struct packed {
		logic  load;
		logic  idx_clr;
		logic  idx_inc;
		logic  add_wr;
		logic  free_cur;
		logic  div_start;
		logic  rearm_wr;
		logic  min_clr;
		logic  min_step;
		logic  skew_load;
		logic  skew_wr;
		emit_t emit;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic cur_active;
		logic cur_due_le_now;
		logic cur_match;
		logic cur_single;
		logic idx_last;
		logic full;
		logic div_busy;
		logic min_valid;
		logic min_overdue;
		logic skew_hit;
	} stat_t;
endpackage
`default_nettype wire

// ===== sv/ptt_div.sv =====
// Iterative remainder unit: one dividend bit per cycle over all 32 bits.
// Depends on ptt_pkg.
`default_nettype none
module ptt_div import ptt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [23:0] divisor,
	output logic             busy,
	output logic [23:0]      rem
);
	logic [5:0]  cnt_q;
	logic [31:0] num_q;
	logic [23:0] rem_q;
	logic [23:0] den_q;
	logic [24:0] trial;
	logic        fits;

	// shift in the next dividend bit and try the subtract
	assign trial = {rem_q, num_q[31]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[30:0], 1'b0};
			rem_q <= fits ? 24'(trial - {1'b0, den_q}) : trial[23:0];
		end
	end

	assign busy = cnt_q != '0;
	assign rem  = rem_q;
endmodule
`default_nettype wire

// ===== sv/ptt_datapath.sv =====
// Datapath of the timer table: slot store, scan index, minimum tracker,
// skew adjust and result register. Depends on ptt_pkg and ptt_div.
`default_nettype none
module ptt_datapath import ptt_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire item_t   item,
	input  wire logic [15:0] skew_thr,
	input  wire cmd_t    cmd,
	output stat_t        stat,
	output result_t      result,
	output logic         strobe
);
	item_t             it_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SLOTS-1:0]  active_q;
	logic [15:0]       key_q    [SLOTS];
	logic [31:0]       due_q    [SLOTS];
	logic [23:0]       period_q [SLOTS];
	logic              single_q [SLOTS];
	logic [IDX_W-1:0]  min_idx_q;
	logic [31:0]       min_due_q;
	logic              min_valid_q;
	logic [31:0]       skew_q;
	result_t           res_q;
	logic              strobe_q;

	logic [IDX_W-1:0]  free_idx;
	logic              full;
	logic [31:0]       cur_due;
	logic [23:0]       cur_per;
	logic [23:0]       div_den;
	logic              div_busy;
	logic [23:0]       div_rem;
	logic [32:0]       add_sum;
	logic [31:0]       add_due;
	logic [32:0]       rearm_sum;
	logic [31:0]       td;
	logic [23:0]       min_per;
	logic [24:0]       lim;
	result_t           res_d;

	// lowest free slot
	always_comb begin
		free_idx = '0;
		full = 1'b1;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_idx = IDX_W'(i);
				full = 1'b0;
			end
		end
	end

	assign cur_due = due_q[idx_q];
	assign cur_per = period_q[idx_q];
	assign div_den = (cur_per == '0) ? 24'd1 : cur_per;

	// remainder of the missed time over the period
	ptt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (it_q.now_ms - cur_due),
		.divisor  (div_den),
		.busy     (div_busy),
		.rem      (div_rem)
	);

	// deadline of a new timer: now + interval, saturating, for a late add or a one-shot; else now
	assign add_sum = {1'b0, it_q.now_ms} + {9'b0, it_q.interval_ms};
	assign add_due = (it_q.operation == OP_ADD_LATE || it_q.fire_once)
		? (add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0]) : it_q.now_ms;
	// re-armed deadline: now + period - remainder, saturating
	assign rearm_sum = {1'b0, it_q.now_ms} + {9'b0, div_den} - {9'b0, div_rem};

	// skew check on the earliest deadline
	assign td      = min_due_q - it_q.now_ms;
	assign min_per = period_q[min_idx_q];
	assign lim     = {1'b0, min_per} + {9'b0, skew_thr};

	// slot store and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			idx_q       <= '0;
			min_valid_q <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= cmd.emit != EM_NONE;
			if (cmd.load || cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.add_wr) begin
				active_q[free_idx] <= 1'b1;
			end
			if (cmd.free_cur) begin
				active_q[idx_q] <= 1'b0;
			end
			if (cmd.min_clr) begin
				min_valid_q <= 1'b0;
			end else if (cmd.min_step && active_q[idx_q]
					&& (!min_valid_q || cur_due < min_due_q)) begin
				min_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			it_q <= item;
		end
		if (cmd.add_wr) begin
			key_q[free_idx]    <= it_q.owner_key;
			period_q[free_idx] <= it_q.interval_ms;
			single_q[free_idx] <= it_q.fire_once;
			due_q[free_idx]    <= add_due;
		end
		if (cmd.rearm_wr) begin
			due_q[idx_q] <= rearm_sum[32] ? 32'hFFFF_FFFF : rearm_sum[31:0];
		end
		if (cmd.skew_wr && active_q[idx_q]) begin
			due_q[idx_q] <= (cur_due >= skew_q) ? cur_due - skew_q : '0;
		end
		if (cmd.min_step && active_q[idx_q] && (!min_valid_q || cur_due < min_due_q)) begin
			min_idx_q <= idx_q;
			min_due_q <= cur_due;
		end
		if (cmd.skew_load) begin
			skew_q <= td - {8'b0, min_per};
		end
		res_q <= res_d;
	end

	// build the result for the current emit code
	always_comb begin
		res_d = '0;
		res_d.kind = KIND_STATUS;
		res_d.last = 1'b1;
		unique case (cmd.emit)
			EM_FIRE: begin
				res_d.kind = KIND_FIRED;
				res_d.last = 1'b0;
				res_d.slot = 4'(idx_q);
				res_d.fired_key = key_q[idx_q];
			end
			EM_ADD:       res_d.slot = 4'(free_idx);
			EM_FULL:      res_d.status = ST_FULL;
			EM_REM_OK:    res_d.slot = 4'(idx_q);
			EM_NOT_FOUND: res_d.status = ST_NOT_FOUND;
			EM_NO_TIMERS: res_d.status = ST_NO_TIMERS;
			EM_DELAY:     res_d.delay_ms = td;
			EM_SKEW:      res_d.skew_corrected = 1'b1;
			EM_OVERDUE, EM_NONE: res_d.status = ST_OK;
			default:      res_d.status = ST_OK;
		endcase
	end

	always_comb begin
		stat.op             = it_q.operation;
		stat.cur_active     = active_q[idx_q];
		stat.cur_due_le_now = cur_due <= it_q.now_ms;
		stat.cur_match      = key_q[idx_q] == it_q.owner_key;
		stat.cur_single     = single_q[idx_q];
		stat.idx_last       = idx_q == IDX_W'(SLOTS - 1);
		stat.full           = full;
		stat.div_busy       = div_busy;
		stat.min_valid      = min_valid_q;
		stat.min_overdue    = min_due_q < it_q.now_ms;
		stat.skew_hit       = {1'b0, td} > {8'b0, lim};
	end

	assign result = res_q;
	assign strobe = strobe_q;
endmodule
`default_nettype wire

// ===== sv/ptt_ctrl.sv =====
// Controller of the timer table: sequences add, remove and process scans.
// Depends on ptt_pkg and the assertion macro header.
`default_nettype none
`include "periodic_timer_table_unit_defines.svh"
module ptt_ctrl import ptt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire stat_t stat,
	output cmd_t       cmd,
	output logic       busy
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_ADD;
			S_ADD: begin
				unique case (stat.op)
					OP_REMOVE:  state_d = S_REM;
					OP_PROCESS: state_d = S_FIRE;
					default:    state_d = S_IDLE;
				endcase
			end
			S_REM: begin
				if ((stat.cur_active && stat.cur_match) || stat.idx_last) state_d = S_IDLE;
			end
			S_FIRE: begin
				if (stat.cur_active && stat.cur_due_le_now && !stat.cur_single) begin
					state_d = S_DIV;
				end else if (stat.idx_last) begin
					state_d = S_MIN;
				end
			end
			S_DIV:   if (!stat.div_busy) state_d = S_REARM;
			S_REARM: state_d = stat.idx_last ? S_MIN : S_FIRE;
			S_MIN:   if (stat.idx_last) state_d = S_DECIDE;
			S_DECIDE: begin
				if (stat.min_valid && !stat.min_overdue && stat.skew_hit) state_d = S_SKEW;
				else state_d = S_IDLE;
			end
			S_SKEW:  if (stat.idx_last) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.emit = EM_NONE;
		unique case (state_q)
			S_IDLE: cmd.load = start;
			S_ADD: begin
				if (stat.op == OP_ADD || stat.op == OP_ADD_LATE) begin
					if (stat.full) begin
						cmd.emit = EM_FULL;
					end else begin
						cmd.add_wr = 1'b1;
						cmd.emit = EM_ADD;
					end
				end
			end
			S_REM: begin
				if (stat.cur_active && stat.cur_match) begin
					cmd.free_cur = 1'b1;
					cmd.emit = EM_REM_OK;
				end else if (stat.idx_last) begin
					cmd.emit = EM_NOT_FOUND;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_FIRE: begin
				if (stat.cur_active && stat.cur_due_le_now) begin
					cmd.emit = EM_FIRE;
					cmd.free_cur = stat.cur_single;
					cmd.div_start = !stat.cur_single;
				end
				if (!(stat.cur_active && stat.cur_due_le_now && !stat.cur_single)) begin
					cmd.idx_clr = stat.idx_last;
					cmd.min_clr = stat.idx_last;
					cmd.idx_inc = !stat.idx_last;
				end
			end
			S_REARM: begin
				cmd.rearm_wr = 1'b1;
				cmd.idx_clr = stat.idx_last;
				cmd.min_clr = stat.idx_last;
				cmd.idx_inc = !stat.idx_last;
			end
			S_MIN: begin
				cmd.min_step = 1'b1;
				cmd.idx_inc = !stat.idx_last;
			end
			S_DECIDE: begin
				if (!stat.min_valid) cmd.emit = EM_NO_TIMERS;
				else if (stat.min_overdue) cmd.emit = EM_OVERDUE;
				else if (stat.skew_hit) begin
					cmd.skew_load = 1'b1;
					cmd.idx_clr = 1'b1;
				end else cmd.emit = EM_DELAY;
			end
			S_SKEW: begin
				cmd.skew_wr = 1'b1;
				if (stat.idx_last) cmd.emit = EM_SKEW;
				else cmd.idx_inc = 1'b1;
			end
			S_DIV: cmd = cmd;
			default: cmd = cmd;
		endcase
	end

	`PTT_ASSERT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy)
	`PTT_NEVER(a_idle_quiet, clk, arst_n, (state_q == S_IDLE) && (cmd.emit != EM_NONE))
	`PTT_ASSERT(a_status_ends, clk, arst_n, (cmd.emit != EM_NONE && cmd.emit != EM_FIRE) |=> !busy)
	`PTT_NEVER(a_div_wait, clk, arst_n, (state_q == S_REARM) && stat.div_busy)
endmodule
`default_nettype wire

// ===== sv/periodic_timer_table_unit.sv =====
// Periodic timer table: 16 timer slots with add, remove and process.
// An item is taken when start is high and busy low. Busy then stays high
// while the item is handled: an add needs no scan, and a remove scans the
// slots in order until the key matches or the last slot. Process makes one
// pass over the slots to fire (one result per cycle while no fired periodic
// slot is being re-armed), a second pass for the earliest deadline and a
// decide step; each fired periodic slot waits on the one-bit-per-cycle
// remainder unit that re-arms it, and a skew correction adds a third pass.
// The final status of an item shows up in the first cycle busy is low. Each
// result sits on the result port for one cycle with strobe high; the
// receiver cannot stall it. Depends on ptt_pkg, ptt_ctrl and ptt_datapath.
`default_nettype none
module periodic_timer_table_unit import ptt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire item_t              item,
	output result_t                 result,
	output logic                    strobe,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	logic [15:0] skew_thr_q;
	cmd_t        cmd;
	stat_t       stat;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skew_thr_q <= SKEW_THR_RESET;
		end else if (psel && penable && pwrite && paddr == '0) begin
			skew_thr_q <= pwdata[15:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == '0) ? {16'b0, skew_thr_q} : '0;

	ptt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	ptt_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.skew_thr (skew_thr_q),
		.cmd      (cmd),
		.stat     (stat),
		.result   (result),
		.strobe   (strobe)
	);
endmodule
`default_nettype wire
